FILE: rtl/les_pkg.sv
package les_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    // register and side width, fixed by the register map
    localparam int SIZE_W = 11;
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;

    localparam t_size MAX_COLUMNS_SIZE = SIZE_W'(MAX_COLUMNS);
    localparam t_size MAX_ROWS_SIZE    = SIZE_W'(MAX_ROWS);
    localparam t_size SIZE_RESET       = 11'd1024;

    // configuration register indexes
    localparam logic [0:0] REG_GRID_COLUMNS = 1'b0;
    localparam logic [0:0] REG_GRID_ROWS    = 1'b1;

    typedef struct packed {
        t_size cols;
        t_size rows;
    } t_grid_size;

    typedef struct packed {
        t_size side;
        t_row  top;
        t_col  left;
    } t_result;

    typedef struct packed {
        logic    grid_end;
        t_result res;
    } t_step;

    // zero acts as one, oversize acts as the limit
    function automatic t_size clamp_size(t_size v, t_size lim);
        t_size r;
        if (v == '0) begin
            r = t_size'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/les_row_mem.sv
module les_row_mem (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  les_pkg::t_col i_wr_addr,
    input  les_pkg::t_size i_wr_data,
    input  les_pkg::t_col i_rd_addr,
    output les_pkg::t_size o_rd_data
);
    import les_pkg::*;

    t_size mem [MAX_COLUMNS];
    t_size r_rd_q;
    t_size r_fwd_data;
    logic  r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_q     <= mem[i_rd_addr];
        r_fwd_data <= i_wr_data;
    end

    // read during write to the same entry returns the new value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_q;

endmodule

FILE: rtl/les_dp_core.sv
module les_dp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  les_pkg::t_grid_size i_size,
    input  logic               i_accept,
    input  logic               i_cell_blocked,
    input  les_pkg::t_size     i_up_raw,
    output les_pkg::t_col      o_rd_addr,
    output logic               o_wr_en,
    output les_pkg::t_col      o_wr_addr,
    output les_pkg::t_size     o_wr_data,
    output les_pkg::t_step     o_step
);
    import les_pkg::*;

    t_col  r_col_cnt, n_col_cnt;
    t_row  r_row_cnt, n_row_cnt;
    t_size r_left, n_left;
    t_size r_ul, n_ul;
    t_size r_best_side, n_best_side;
    t_row  r_best_top, n_best_top;
    t_col  r_best_left, n_best_left;

    t_size cols, rows;
    t_col  col;
    t_row  row;
    t_size up, diag, left, m_ab, m_min, side;
    t_size top_full, lft_full;
    t_row  top;
    t_col  lft;
    logic  better, row_end, grid_end;

    always_comb begin
        cols = clamp_size(i_size.cols, MAX_COLUMNS_SIZE);
        rows = clamp_size(i_size.rows, MAX_ROWS_SIZE);
        col  = (SIZE_W'(r_col_cnt) >= cols) ? COL_W'(cols - 1'b1) : r_col_cnt;
        row  = (SIZE_W'(r_row_cnt) >= rows) ? ROW_W'(rows - 1'b1) : r_row_cnt;

        up   = (row != '0) ? i_up_raw : '0;
        diag = (row != '0 && col != '0) ? r_ul : '0;
        left = (col != '0) ? r_left : '0;

        m_ab  = (up < left) ? up : left;
        m_min = (m_ab < diag) ? m_ab : diag;
        side  = i_cell_blocked ? '0 : m_min + 1'b1;

        // top-left corner of the square ending here
        top_full = SIZE_W'(row) + 1'b1 - side;
        lft_full = SIZE_W'(col) + 1'b1 - side;
        top      = top_full[ROW_W-1:0];
        lft      = lft_full[COL_W-1:0];

        better = (side != '0) &&
                 ((side > r_best_side) ||
                  ((side == r_best_side) &&
                   ((top < r_best_top) ||
                    ((top == r_best_top) && (lft < r_best_left)))));

        row_end  = (SIZE_W'(col) + 1'b1) >= cols;
        grid_end = row_end && ((SIZE_W'(row) + 1'b1) >= rows);

        n_best_side = better ? side : r_best_side;
        n_best_top  = better ? top  : r_best_top;
        n_best_left = better ? lft  : r_best_left;

        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        n_left    = r_left;
        n_ul      = r_ul;
        if (i_accept) begin
            priority if (grid_end) begin
                n_col_cnt   = '0;
                n_row_cnt   = '0;
                n_left      = '0;
                n_ul        = '0;
            end else if (row_end) begin
                n_col_cnt = '0;
                n_row_cnt = row + 1'b1;
                n_left    = '0;
                n_ul      = '0;
            end else begin
                n_col_cnt = col + 1'b1;
                n_row_cnt = row;
                n_left    = side;
                n_ul      = up;
            end
        end

        // fetch the entry the next cell will need
        o_rd_addr = i_accept ? (row_end ? '0 : col + 1'b1) : col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_left      <= '0;
            r_ul        <= '0;
            r_best_side <= '0;
            r_best_top  <= '0;
            r_best_left <= '0;
        end else begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
            r_left    <= n_left;
            r_ul      <= n_ul;
            if (i_accept) begin
                if (grid_end) begin
                    r_best_side <= '0;
                    r_best_top  <= '0;
                    r_best_left <= '0;
                end else begin
                    r_best_side <= n_best_side;
                    r_best_top  <= n_best_top;
                    r_best_left <= n_best_left;
                end
            end
        end
    end

    assign o_wr_en            = i_accept;
    assign o_wr_addr          = col;
    assign o_wr_data          = side;
    assign o_step.grid_end    = grid_end;
    assign o_step.res.side    = n_best_side;
    assign o_step.res.top     = n_best_top;
    assign o_step.res.left    = n_best_left;

endmodule

FILE: rtl/largest_empty_square_finder.sv
// largest free square finder over a streamed grid
//
// input channel: i_valid / o_stall carry one grid cell per transfer
// (i_cell_blocked), row-major, grid_columns cells per row, grid_rows rows
// output channel: o_valid / i_stall carry one result per grid: side of the
// largest free square and its top-left row and column (ties to the first
// corner in row-major order); all zero when no cell is free
// config: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 = grid_columns, 1 = grid_rows); 0 acts as 1, values above 1024 as 1024
// throughput: one cell per cycle while o_stall is low; the row buffer read for
// the next cell is issued in the cycle of the current cell, so the one-row
// memory sets the rate; o_valid rises in the cycle after a grid's last cell
// o_stall is raised for one cycle after each config write while the row
// buffer read is refetched, and while a result waits under i_stall
// cells keep flowing while the output stage holds a result that is not stalled
// reset: synchronous, active low; sizes return to 1024, counters and best
// square clear, the row buffer needs no clearing
module largest_empty_square_finder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  les_pkg::t_size       i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cell_blocked,
    output logic                 o_valid,
    input  logic                 i_stall,
    output les_pkg::t_size       o_square_side,
    output les_pkg::t_row        o_top_row,
    output les_pkg::t_col        o_left_column
);
    import les_pkg::*;

    t_grid_size r_size;
    logic       r_cfg_hold;
    logic       r_out_valid;
    t_result    r_out;

    logic  accept;
    logic  load;
    t_col  rd_addr;
    logic  wr_en;
    t_col  wr_addr;
    t_size wr_data;
    t_size up_raw;
    t_step step;

    // hold input while output is full and stalled, or a read is being refetched
    assign o_stall = r_cfg_hold || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign load    = accept && step.grid_end;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size.cols <= SIZE_RESET;
            r_size.rows <= SIZE_RESET;
            r_cfg_hold  <= 1'b0;
        end else begin
            r_cfg_hold <= i_cfg_we;
            if (i_cfg_we) begin
                priority if (i_cfg_index == REG_GRID_COLUMNS) begin
                    r_size.cols <= i_cfg_data;
                end else if (i_cfg_index == REG_GRID_ROWS) begin
                    r_size.rows <= i_cfg_data;
                end
            end
        end
    end

    les_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (up_raw)
    );

    les_dp_core u_dp_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_size         (r_size),
        .i_accept       (accept),
        .i_cell_blocked (i_cell_blocked),
        .i_up_raw       (up_raw),
        .o_rd_addr      (rd_addr),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_step         (step)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= step.res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_square_side = r_out.side;
    assign o_top_row     = r_out.top;
    assign o_left_column = r_out.left;

`ifndef SYNTHESIS
    // no cell taken in the cycle after a config write
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall)
        else $error("cell taken during row buffer refetch");

    // a waiting result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !accept)
        else $error("cell taken while result stalled");

    // the last cell of a grid yields a result next cycle
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_valid)
        else $error("grid end without result");
`endif

endmodule

FILE: sim/largest_empty_square_finder_tb.sv
`timescale 1ns / 100ps

module largest_empty_square_finder_tb;
    import les_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    // result shows in the cycle after the last cell, plus margin for the output stage
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_CELLS = 1050;

    // tracks the dp row and the best square; holds the squares still owed by the block
    class square_scoreboard;
        t_size   cols_reg;
        t_size   rows_reg;
        t_size   sides_above [MAX_COLUMNS];
        int      left_run;
        int      upper_left_run;
        int      row_pos;
        int      col_pos;
        int      best_side;
        int      best_top;
        int      best_left;
        int      written_upto;
        int      grids_done;
        int      errors;
        t_result expected_squares [$];

        function new();
            cols_reg     = SIZE_RESET;
            rows_reg     = SIZE_RESET;
            written_upto = 0;
            grids_done   = 0;
            errors       = 0;
            foreach (sides_above[i]) sides_above[i] = '0;
            restart_grid();
        endfunction

        function void restart_grid();
            left_run       = 0;
            upper_left_run = 0;
            row_pos        = 0;
            col_pos        = 0;
            best_side      = 0;
            best_top       = 0;
            best_left      = 0;
        endfunction

        // zero acts as one, anything past the limit acts as the limit
        function int eff_size(t_size v, int lim);
            if (v == '0) return 1;
            if (int'(v) > lim) return lim;
            return int'(v);
        endfunction

        // past the first row a wider grid would read row entries never written
        function t_size safe_cols(t_size v);
            if (row_pos > 0 && eff_size(v, MAX_COLUMNS) > written_upto)
                return t_size'(written_upto);
            return v;
        endfunction

        function void write_reg(logic [0:0] idx, t_size val);
            if (idx == REG_GRID_COLUMNS) cols_reg = val;
            else rows_reg = val;
        endfunction

        function void note_cell(logic blocked);
            int      ncols;
            int      nrows;
            int      c;
            int      r;
            int      up;
            int      diag;
            int      lf;
            int      s;
            int      top;
            int      lft;
            t_result sq;

            ncols = eff_size(cols_reg, MAX_COLUMNS);
            nrows = eff_size(rows_reg, MAX_ROWS);
            // a counter past a shrunken size sits on the last index
            c = (col_pos >= ncols) ? ncols - 1 : col_pos;
            r = (row_pos >= nrows) ? nrows - 1 : row_pos;

            up   = (r > 0) ? int'(sides_above[c]) : 0;
            diag = (r > 0 && c > 0) ? upper_left_run : 0;
            lf   = (c > 0) ? left_run : 0;

            if (blocked) begin
                s = 0;
            end else begin
                s = up;
                if (lf < s) s = lf;
                if (diag < s) s = diag;
                s = s + 1;
            end

            if (s > 0) begin
                top = r + 1 - s;
                lft = c + 1 - s;
                // ties go to the corner that comes first in row-major order
                if (s > best_side || (s == best_side &&
                    (top < best_top || (top == best_top && lft < best_left)))) begin
                    best_side = s;
                    best_top  = top;
                    best_left = lft;
                end
            end

            upper_left_run = up;
            left_run       = s;
            sides_above[c] = t_size'(s);
            if (c + 1 > written_upto) written_upto = c + 1;

            if (c + 1 >= ncols && r + 1 >= nrows) begin
                sq.side = t_size'(best_side);
                sq.top  = t_row'(best_top);
                sq.left = t_col'(best_left);
                expected_squares.push_back(sq);
                grids_done++;
                restart_grid();
            end else if (c + 1 >= ncols) begin
                col_pos        = 0;
                row_pos        = r + 1;
                left_run       = 0;
                upper_left_run = 0;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_square(t_result got);
            t_result want;
            if (expected_squares.size() == 0) begin
                $error("square with no grid pending: side %0d top %0d left %0d",
                       got.side, got.top, got.left);
                errors++;
                return;
            end
            want = expected_squares.pop_front();
            if (got.side !== want.side) begin
                $error("square_side expected %0d actual %0d", want.side, got.side);
                errors++;
            end
            if (got.top !== want.top) begin
                $error("top_row expected %0d actual %0d", want.top, got.top);
                errors++;
            end
            if (got.left !== want.left) begin
                $error("left_column expected %0d actual %0d", want.left, got.left);
                errors++;
            end
        endfunction
    endclass

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         cfg_we       = 1'b0;
    logic [0:0]   cfg_index    = REG_GRID_COLUMNS;
    t_size        cfg_data     = '0;
    logic         cell_valid   = 1'b0;
    logic         cell_stall;
    logic         cell_blocked = 1'b0;
    logic         sq_valid;
    logic         sq_stall     = 1'b0;
    t_size        sq_side;
    t_row         sq_top;
    t_col         sq_left;

    square_scoreboard sb;
    int  cycle_count = 0;
    int  cells_sent  = 0;
    bit  calm        = 1'b0;

    largest_empty_square_finder uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (cell_valid),
        .o_stall        (cell_stall),
        .i_cell_blocked (cell_blocked),
        .o_valid        (sq_valid),
        .i_stall        (sq_stall),
        .o_square_side  (sq_side),
        .o_top_row      (sq_top),
        .o_left_column  (sq_left)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // random backpressure on the result side, none during the calm stretch
    always @(posedge clk) begin
        sq_stall <= !calm && ($urandom_range(0, 99) < 24);
    end

    // result monitor: one transfer per edge with valid high and stall low
    always @(posedge clk) begin
        if (rst_n && sq_valid && !sq_stall) begin
            sb.check_square(t_result'({sq_side, sq_top, sq_left}));
        end
    end

    // one cell transfer; valid stays high when the next cell follows at once
    task automatic send_cell(input logic blocked);
        while (!calm && $urandom_range(0, 99) < 24) begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid   <= 1'b1;
        cell_blocked <= blocked;
        @(posedge clk);
        while (cell_stall) @(posedge clk);
        sb.note_cell(blocked);
        cells_sent++;
    endtask

    // cells listed msb first
    task automatic send_bits(input logic [31:0] bits, input int count);
        for (int k = count - 1; k >= 0; k--) send_cell(bits[k]);
    endtask

    task automatic run_grids(input int count, input int pct);
        int target;
        target = sb.grids_done + count;
        while (sb.grids_done < target) send_cell($urandom_range(0, 99) < pct);
    endtask

    // hold input off until every owed square is out and the pipe has settled
    task automatic drain();
        cell_valid <= 1'b0;
        while (sb.expected_squares.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write enable is lowered once, after the last write
    task automatic configure(input bit set_cols, input t_size cols,
                             input bit set_rows, input t_size rows);
        t_size cols_val;
        cols_val = sb.safe_cols(cols);
        if (set_cols) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_GRID_COLUMNS;
            cfg_data  <= cols_val;
            @(posedge clk);
            sb.write_reg(REG_GRID_COLUMNS, cols_val);
        end
        if (set_rows) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_GRID_ROWS;
            cfg_data  <= rows;
            @(posedge clk);
            sb.write_reg(REG_GRID_ROWS, rows);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_density();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            3:       return 40;
            4:       return 70;
            default: return 100;
        endcase
    endfunction

    // mostly small sizes, some zero, oversize only where asked
    function automatic t_size pick_size(input bit allow_over);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (allow_over && roll < 20)
            return t_size'($urandom_range(MAX_ROWS + 1, (1 << SIZE_W) - 1));
        if (roll < 80) return t_size'($urandom_range(1, 8));
        return t_size'($urandom_range(9, 24));
    endfunction

    initial begin
        int    start_mark;
        int    pct;
        int    ncols;
        int    nrows;
        t_size cols;
        t_size rows;
        bit    set_cols;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single cell grid, free then blocked
        configure(1'b1, 11'd1, 1'b1, 11'd1);
        send_cell(1'b0);
        send_cell(1'b1);

        // no free cell at all
        drain();
        configure(1'b1, 11'd2, 1'b1, 11'd2);
        send_bits(32'b1111, 4);

        // 3x3 with two opposite corners blocked: tie between side-2 squares
        drain();
        configure(1'b1, 11'd3, 1'b1, 11'd3);
        send_bits(32'b100_000_001, 9);

        // oversize rows, then shrink columns and rows while inside the grid
        drain();
        configure(1'b1, 11'd4, 1'b1, 11'd2047);
        send_bits(32'b0, 6);
        drain();
        configure(1'b1, 11'd2, 1'b0, '0);
        send_cell(1'b0);
        drain();
        configure(1'b0, '0, 1'b1, 11'd0);
        send_bits(32'b0, 2);

        // oversize columns, zero rows, then cut the row short
        drain();
        configure(1'b1, 11'd2047, 1'b1, 11'd0);
        send_bits(32'h2491_0a5c, 30);
        drain();
        configure(1'b1, 11'd3, 1'b0, '0);
        send_cell(1'b0);

        start_mark  = cells_sent;
        set_cols    = 1'b1;
        while (cells_sent - start_mark < RANDOM_CELLS) begin
            calm = (cells_sent - start_mark >= 400) && (cells_sent - start_mark < 650);
            pct  = pick_density();

            // keep the sizes for some phases so grids run back to back
            if (set_cols || $urandom_range(0, 9) < 7) begin
                cols = pick_size(1'b0);
                rows = pick_size(1'b1);
                drain();
                if ($urandom_range(0, 3) == 0) begin
                    configure(set_cols, cols, 1'b1, rows);
                end else if ($urandom_range(0, 2) == 0) begin
                    configure(1'b1, cols, set_cols, rows);
                end else begin
                    configure(1'b1, cols, 1'b1, rows);
                end
                set_cols = 1'b0;
            end

            ncols = sb.eff_size(sb.cols_reg, MAX_COLUMNS);
            nrows = sb.eff_size(sb.rows_reg, MAX_ROWS);
            if (ncols * nrows > 600) begin
                // far too tall: start it, then cut the rows down mid-grid
                repeat ($urandom_range(1, (3 * ncols < 60) ? 3 * ncols : 60))
                    send_cell($urandom_range(0, 99) < pct);
                drain();
                configure(1'b0, '0, 1'b1, pick_size(1'b0));
                run_grids(1, pct);
            end else begin
                run_grids($urandom_range(1, 4), pct);
                if ($urandom_range(0, 3) == 0) begin
                    // broken grid: resize partway through
                    repeat ($urandom_range(1, ncols * nrows))
                        send_cell($urandom_range(0, 99) < pct);
                    drain();
                    if ($urandom_range(0, 1) == 0)
                        configure(1'b1, pick_size(1'b0), 1'b0, '0);
                    else
                        configure(1'b0, '0, 1'b1, pick_size(1'b0));
                    run_grids(1, pct);
                end
            end
        end
        calm = 1'b0;

        drain();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
